[src/prcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Partition rank and crank package
// Shared widths, register indexes, statistic codes, the control group of the
// part chain and the saturating result helper.
// ----------------------------------------------------------------------------
package prcs_pkg;

    localparam int MAX_ENTRIES    = 64;
    localparam int PART_BITS      = 12;
    localparam int TOTAL_BITS     = 12;
    localparam int MODE_BITS      = 2;
    localparam int STAT_BITS      = 13;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = TOTAL_BITS;
    localparam int COUNT_BITS     = $clog2(MAX_ENTRIES + 1);
    localparam int RESULT_MAX     = (1 << STAT_BITS) - 1;

    localparam int WIDEST_BITS    = (PART_BITS > TOTAL_BITS) ? PART_BITS : TOTAL_BITS;
    localparam int OPERAND_BITS   = (WIDEST_BITS > STAT_BITS) ? WIDEST_BITS : STAT_BITS;
    localparam int CALC_BITS      = OPERAND_BITS + 1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_STATISTIC_MODE    = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_PARTITIONED_TOTAL = CFG_INDEX_BITS'(1);

    localparam logic [MODE_BITS-1:0] MODE_NUMBER_OF_PARTS = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_LARGEST_PART    = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_RANK            = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_CRANK           = 2'd3;

    typedef struct packed {
        logic                 load;
        logic                 drain;
        logic [PART_BITS-1:0] value;
    } chain_ctrl_t;

    function automatic logic [STAT_BITS-1:0] sat_result(
        input logic [CALC_BITS-1:0] minuend,
        input logic [CALC_BITS-1:0] subtrahend
    );
        logic [CALC_BITS-1:0] diff;
        diff = minuend - subtrahend;
        if (minuend < subtrahend) begin
            sat_result = '0;
        end
        else if (diff > CALC_BITS'(RESULT_MAX)) begin
            sat_result = STAT_BITS'(RESULT_MAX);
        end
        else begin
            sat_result = diff[STAT_BITS-1:0];
        end
    endfunction

endpackage

[src/prcs_part_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Part entry channel
// Carries one row entry per beat with the flag that marks the row's end.
// ----------------------------------------------------------------------------
interface prcs_part_if;

    logic                           valid;
    logic                           ready;
    logic [prcs_pkg::PART_BITS-1:0] part_value;
    logic                           row_end;

    modport source (output valid, output part_value, output row_end, input ready);
    modport sink   (input valid, input part_value, input row_end, output ready);

endinterface

[src/prcs_stat_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Statistic result channel
// Carries the chosen statistic of one finished row per beat.
// ----------------------------------------------------------------------------
interface prcs_stat_if;

    logic                           valid;
    logic                           ready;
    logic [prcs_pkg::STAT_BITS-1:0] statistic_value;

    modport source (output valid, output statistic_value, input ready);
    modport sink   (input valid, input statistic_value, output ready);

endinterface

[src/prcs_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and write data per beat.
// ----------------------------------------------------------------------------
interface prcs_cfg_if;

    logic                                valid;
    logic                                ready;
    logic [prcs_pkg::CFG_INDEX_BITS-1:0] index;
    logic [prcs_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

[src/prcs_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Part chain cell
// Holds one stored part; shifts up from its lower neighbour while the row
// loads and down from its upper neighbour while the row is drained.
// ----------------------------------------------------------------------------
module prcs_cell (
    input  logic                           clk,
    input  prcs_pkg::chain_ctrl_t          ctrl,
    input  logic [prcs_pkg::PART_BITS-1:0] prev_value,
    input  logic [prcs_pkg::PART_BITS-1:0] next_value,
    output logic [prcs_pkg::PART_BITS-1:0] value
);
    import prcs_pkg::*;

    logic [PART_BITS-1:0] value_reg;
    logic [PART_BITS-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.load) begin
            value_next = prev_value;
        end
        else if (ctrl.drain) begin
            value_next = next_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

[src/prcs_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Part chain
// A row of cells holding the parts of the current row, newest at the head.
// ----------------------------------------------------------------------------
module prcs_chain (
    input  logic                           clk,
    input  prcs_pkg::chain_ctrl_t          ctrl,
    output logic [prcs_pkg::PART_BITS-1:0] head_value
);
    import prcs_pkg::*;

    logic [PART_BITS-1:0] cell_value [MAX_ENTRIES];

    for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
        logic [PART_BITS-1:0] prev_value;
        logic [PART_BITS-1:0] next_value;

        if (k == 0) begin : g_first
            assign prev_value = ctrl.value;
        end
        else begin : g_inner_prev
            assign prev_value = cell_value[k-1];
        end

        if (k == MAX_ENTRIES - 1) begin : g_last
            assign next_value = cell_value[k];
        end
        else begin : g_inner_next
            assign next_value = cell_value[k+1];
        end

        prcs_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .prev_value (prev_value),
            .next_value (next_value),
            .value      (cell_value[k])
        );
    end

    assign head_value = cell_value[0];

endmodule

[src/partition_rank_crank_statistic_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Partition rank and crank statistic
// Collects one partition row and reports its part count, largest part, rank
// or crank as the mode register selects.
// ----------------------------------------------------------------------------
// Entries arrive on part_in, one beat each, with row_end on the last one. A
// row's parts are the entries before its first zero; they shift into a chain
// of cells, one cell per part. Entries beyond the chain length are dropped.
// One beat on stat_out follows each row. Registers are written on cfg, which
// is always ready. The user must write them only while the block is idle;
// the block itself does not enforce it. Ordinary entries are taken one per
// cycle while part_in is ready. After the row_end beat a finishing state
// forms the result in the result register, from which it moves to the output
// register; part_in is held off in that state and while the result register
// is full. For a crank with ones present the finishing state is followed by
// a drain of the chain through its head cell, one part per cycle, after which
// the drain state forms the result.
// When the receiver stalls, the output register keeps its beat and the next
// row is still taken; part_in stops while a second result waits in the
// result register, until the receiver takes the waiting beat.
// Reset clears the registers, the row state and both result stages; the
// chain contents need no clearing since only parts of the current row are
// read.
// ----------------------------------------------------------------------------
module partition_rank_crank_statistic_top (
    input  logic              clk,
    input  logic              rst_n,
    prcs_part_if.sink         part_in,
    prcs_stat_if.source       stat_out,
    prcs_cfg_if.sink          cfg
);
    import prcs_pkg::*;

    typedef enum logic [1:0] {
        S_LOAD,
        S_FINISH,
        S_DRAIN
    } state_t;

    state_t                state_reg, state_next;
    logic [MODE_BITS-1:0]  mode_reg, mode_next;
    logic [TOTAL_BITS-1:0] total_reg, total_next;
    logic [COUNT_BITS-1:0] position_reg, position_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [PART_BITS-1:0]  first_reg, first_next;
    logic [COUNT_BITS-1:0] ones_reg, ones_next;
    logic                  zero_seen_reg, zero_seen_next;
    logic [COUNT_BITS-1:0] drain_left_reg, drain_left_next;
    logic [COUNT_BITS-1:0] greater_reg, greater_next;
    logic                  result_valid_reg, result_valid_next;
    logic [STAT_BITS-1:0]  result_reg, result_next;
    logic                  out_valid_reg, out_valid_next;
    logic [STAT_BITS-1:0]  out_value_reg, out_value_next;

    chain_ctrl_t           chain_ctrl;
    logic [PART_BITS-1:0]  head_value;
    logic                  in_fire;
    logic                  take;
    logic [PART_BITS-1:0]  largest;
    logic [CALC_BITS-1:0]  n_plus_largest;

    prcs_chain u_chain (
        .clk        (clk),
        .ctrl       (chain_ctrl),
        .head_value (head_value)
    );

    assign part_in.ready            = (state_reg == S_LOAD) && !result_valid_reg;
    assign cfg.ready                = 1'b1;
    assign stat_out.valid           = out_valid_reg;
    assign stat_out.statistic_value = out_value_reg;

    assign in_fire = part_in.valid && part_in.ready;
    assign take    = in_fire && (position_reg < COUNT_BITS'(MAX_ENTRIES)) && !zero_seen_reg;
    assign largest = (count_reg != '0) ? first_reg : '0;
    assign n_plus_largest = CALC_BITS'(total_reg) + CALC_BITS'(largest);

    always_comb
    begin
        chain_ctrl.load  = take && (part_in.part_value != '0);
        chain_ctrl.drain = (state_reg == S_DRAIN) && (drain_left_reg != '0);
        chain_ctrl.value = part_in.part_value;
    end

    always_comb
    begin
        state_next        = state_reg;
        mode_next         = mode_reg;
        total_next        = total_reg;
        position_next     = position_reg;
        count_next        = count_reg;
        first_next        = first_reg;
        ones_next         = ones_reg;
        zero_seen_next    = zero_seen_reg;
        drain_left_next   = drain_left_reg;
        greater_next      = greater_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        out_valid_next    = out_valid_reg;
        out_value_next    = out_value_reg;

        if (cfg.valid) begin
            unique case (cfg.index)
                REG_STATISTIC_MODE:    mode_next  = cfg.data[MODE_BITS-1:0];
                REG_PARTITIONED_TOTAL: total_next = cfg.data[TOTAL_BITS-1:0];
                default: ;
            endcase
        end

        if (out_valid_reg && stat_out.ready) begin
            out_valid_next = 1'b0;
        end
        if (result_valid_reg && (!out_valid_reg || stat_out.ready)) begin
            out_valid_next    = 1'b1;
            out_value_next    = result_reg;
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_fire) begin
                    if (position_reg < COUNT_BITS'(MAX_ENTRIES)) begin
                        position_next = position_reg + 1'b1;
                    end
                    if (take) begin
                        if (part_in.part_value == '0) begin
                            zero_seen_next = 1'b1;
                        end
                        else begin
                            count_next = count_reg + 1'b1;
                            if (count_reg == '0) begin
                                first_next = part_in.part_value;
                            end
                            if (part_in.part_value == PART_BITS'(1)) begin
                                ones_next = ones_reg + 1'b1;
                            end
                        end
                    end
                    if (part_in.row_end) begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                result_valid_next = 1'b1;
                state_next        = S_LOAD;
                unique case (mode_reg)
                    MODE_NUMBER_OF_PARTS:
                        result_next = sat_result(CALC_BITS'(count_reg), '0);
                    MODE_LARGEST_PART:
                        result_next = sat_result(CALC_BITS'(largest), '0);
                    MODE_RANK:
                        result_next = sat_result(n_plus_largest, CALC_BITS'(count_reg));
                    MODE_CRANK:
                    begin
                        if (ones_reg == '0) begin
                            result_next = sat_result(n_plus_largest, '0);
                        end
                        else begin
                            result_valid_next = 1'b0;
                            drain_left_next   = count_reg;
                            greater_next      = '0;
                            state_next        = S_DRAIN;
                        end
                    end
                    default: ;
                endcase
                if (state_next == S_LOAD) begin
                    position_next  = '0;
                    count_next     = '0;
                    first_next     = '0;
                    ones_next      = '0;
                    zero_seen_next = 1'b0;
                end
            end
            S_DRAIN:
            begin
                if (drain_left_reg != '0) begin
                    drain_left_next = drain_left_reg - 1'b1;
                    if (CALC_BITS'(head_value) > CALC_BITS'(ones_reg)) begin
                        greater_next = greater_reg + 1'b1;
                    end
                end
                else begin
                    result_next = sat_result(
                        CALC_BITS'(total_reg) + CALC_BITS'(greater_reg),
                        CALC_BITS'(ones_reg));
                    result_valid_next = 1'b1;
                    position_next     = '0;
                    count_next        = '0;
                    first_next        = '0;
                    ones_next         = '0;
                    zero_seen_next    = 1'b0;
                    state_next        = S_LOAD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg        <= S_LOAD;
            mode_reg         <= '0;
            total_reg        <= '0;
            position_reg     <= '0;
            count_reg        <= '0;
            first_reg        <= '0;
            ones_reg         <= '0;
            zero_seen_reg    <= 1'b0;
            drain_left_reg   <= '0;
            greater_reg      <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
            out_valid_reg    <= 1'b0;
            out_value_reg    <= '0;
        end
        else begin
            state_reg        <= state_next;
            mode_reg         <= mode_next;
            total_reg        <= total_next;
            position_reg     <= position_next;
            count_reg        <= count_next;
            first_reg        <= first_next;
            ones_reg         <= ones_next;
            zero_seen_reg    <= zero_seen_next;
            drain_left_reg   <= drain_left_next;
            greater_reg      <= greater_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
            out_valid_reg    <= out_valid_next;
            out_value_reg    <= out_value_next;
        end
    end

endmodule

[dv/prcs_stat_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Partition statistic checker
// Watches the part, statistic and configuration channels, keeps its own copy
// of the registers and of the row being collected, predicts the statistic of
// every finished row and compares each statistic beat with the oldest
// prediction.
// ----------------------------------------------------------------------------
module prcs_stat_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                part_valid,
    input  logic                                part_ready,
    input  logic [prcs_pkg::PART_BITS-1:0]      part_value,
    input  logic                                row_end,
    input  logic                                stat_valid,
    input  logic                                stat_ready,
    input  logic [prcs_pkg::STAT_BITS-1:0]      statistic_value,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [prcs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [prcs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output int                                  fail_count,
    output int                                  pending_results
);
    import prcs_pkg::*;

    localparam int SLOT_BITS = $clog2(MAX_ENTRIES);

    logic [MODE_BITS-1:0]  mode_reg;
    logic [TOTAL_BITS-1:0] total_reg;

    logic [PART_BITS-1:0]  row_parts [MAX_ENTRIES];
    logic [COUNT_BITS-1:0] entries_taken;
    logic [COUNT_BITS-1:0] parts_taken;
    logic [COUNT_BITS-1:0] ones_taken;
    logic [PART_BITS-1:0]  leading_part;
    logic                  zero_hit;

    logic [STAT_BITS-1:0]  stat_expected_q [$];
    logic [STAT_BITS-1:0]  stat_oldest;
    int                    mismatches;

    function automatic logic [STAT_BITS-1:0] predict_statistic();
        int n;
        int largest;
        int count;
        int ones;
        int greater;
        int v;
        int i;
        n       = total_reg;
        count   = parts_taken;
        ones    = ones_taken;
        largest = (count != 0) ? int'(leading_part) : 0;
        case (mode_reg)
            MODE_NUMBER_OF_PARTS: v = count;
            MODE_LARGEST_PART:    v = largest;
            MODE_RANK:            v = n + largest - count;
            default:
            begin
                if (ones == 0) begin
                    v = n + largest;
                end
                else begin
                    greater = 0;
                    for (i = 0; i < count; i++) begin
                        if (int'(row_parts[i]) > ones) begin
                            greater++;
                        end
                    end
                    v = n + greater - ones;
                end
            end
        endcase
        if (v < 0) begin
            v = 0;
        end
        if (v > RESULT_MAX) begin
            v = RESULT_MAX;
        end
        return STAT_BITS'(v);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg      = '0;
            total_reg     = '0;
            entries_taken = '0;
            parts_taken   = '0;
            ones_taken    = '0;
            leading_part  = '0;
            zero_hit      = 1'b0;
            mismatches    = 0;
            stat_expected_q.delete();
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_STATISTIC_MODE) begin
                    mode_reg = cfg_data[MODE_BITS-1:0];
                end
                else if (cfg_index == REG_PARTITIONED_TOTAL) begin
                    total_reg = cfg_data[TOTAL_BITS-1:0];
                end
            end

            if (part_valid && part_ready) begin
                if (entries_taken < MAX_ENTRIES) begin
                    if (!zero_hit) begin
                        if (part_value == '0) begin
                            zero_hit = 1'b1;
                        end
                        else begin
                            row_parts[parts_taken[SLOT_BITS-1:0]] = part_value;
                            if (parts_taken == '0) begin
                                leading_part = part_value;
                            end
                            parts_taken++;
                            if (part_value == PART_BITS'(1)) begin
                                ones_taken++;
                            end
                        end
                    end
                    entries_taken++;
                end
                if (row_end) begin
                    stat_expected_q = {stat_expected_q, predict_statistic()};
                    entries_taken = '0;
                    parts_taken   = '0;
                    ones_taken    = '0;
                    leading_part  = '0;
                    zero_hit      = 1'b0;
                end
            end

            if (stat_valid && stat_ready) begin
                if (stat_expected_q.size() == 0) begin
                    $display("%0t: unexpected statistic beat, expected none, actual %0d",
                             $time, statistic_value);
                    mismatches++;
                end
                else begin
                    stat_oldest = stat_expected_q.pop_front();
                    if (statistic_value !== stat_oldest) begin
                        $display("%0t: statistic mismatch, expected %0d, actual %0d",
                                 $time, stat_oldest, statistic_value);
                        mismatches++;
                    end
                end
            end
        end
        fail_count      <= mismatches;
        pending_results <= stat_expected_q.size();
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Partition statistic testbench
// Drives rows of partition entries and configuration writes into the block,
// with random gaps on the sender and random stalls on the receiver, and gives
// the verdict from the failure count of the checker beside the block.
// ----------------------------------------------------------------------------
module tb_top;

    import prcs_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_COUNT   = 12;
    localparam int PHASE_ITEMS   = 42;

    logic clk;
    logic rst_n = 1'b0;

    prcs_part_if part_bus ();
    prcs_stat_if stat_bus ();
    prcs_cfg_if  cfg_bus ();

    int fail_count;
    int pending_results;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int entries_sent = 0;
    int cycle_count = 0;

    partition_rank_crank_statistic_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .part_in  (part_bus),
        .stat_out (stat_bus),
        .cfg      (cfg_bus)
    );

    prcs_stat_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .part_valid      (part_bus.valid),
        .part_ready      (part_bus.ready),
        .part_value      (part_bus.part_value),
        .row_end         (part_bus.row_end),
        .stat_valid      (stat_bus.valid),
        .stat_ready      (stat_bus.ready),
        .statistic_value (stat_bus.statistic_value),
        .cfg_valid       (cfg_bus.valid),
        .cfg_ready       (cfg_bus.ready),
        .cfg_index       (cfg_bus.index),
        .cfg_data        (cfg_bus.data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // The receiver serves a requested hold-off by keeping ready low for a
    // long stretch; otherwise it stalls at random.
    initial
    begin
        stat_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                stat_bus.ready <= 1'b0;
            end
            else begin
                stat_bus.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_entry(input logic [PART_BITS-1:0] value, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            part_bus.valid <= 1'b0;
            @(posedge clk);
        end
        part_bus.valid      <= 1'b1;
        part_bus.part_value <= value;
        part_bus.row_end    <= last;
        @(posedge clk);
        while (!part_bus.ready) begin
            @(posedge clk);
        end
        entries_sent++;
    endtask

    task automatic write_config(input logic [MODE_BITS-1:0] mode,
                                input logic [TOTAL_BITS-1:0] total);
        logic [CFG_INDEX_BITS-1:0] idx [3];
        logic [CFG_DATA_BITS-1:0]  dat [3];
        int k;
        idx[0] = REG_STATISTIC_MODE;
        dat[0] = CFG_DATA_BITS'($urandom);
        dat[0][MODE_BITS-1:0] = mode;
        idx[1] = REG_PARTITIONED_TOTAL;
        dat[1] = total;
        // A write to an index beyond the register list must leave both alone.
        idx[2] = CFG_INDEX_BITS'($urandom_range(REG_PARTITIONED_TOTAL + 1,
                                                (1 << CFG_INDEX_BITS) - 1));
        dat[2] = CFG_DATA_BITS'($urandom);
        for (k = 0; k < 3; k++) begin
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= idx[k];
            cfg_bus.data  <= dat[k];
            @(posedge clk);
            while (!cfg_bus.ready) begin
                @(posedge clk);
            end
        end
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic drain_results();
        part_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Most rows are proper partitions, non-increasing and sometimes padded
    // with zeros; the rest are noise with zeros anywhere.
    task automatic send_random_row();
        int shape;
        int row_len;
        int zeros;
        int j;
        logic [PART_BITS-1:0] cur;
        logic [PART_BITS-1:0] noise;
        shape   = $urandom_range(99);
        row_len = ($urandom_range(99) < 6) ? $urandom_range(40, 72) : $urandom_range(1, 8);
        if (shape < 70) begin
            if ($urandom_range(1) == 1) begin
                cur = PART_BITS'($urandom_range(1, 9));
            end
            else begin
                cur = PART_BITS'($urandom_range(1, (1 << PART_BITS) - 1));
            end
            zeros = ($urandom_range(2) == 0) ? $urandom_range(1, 3) : 0;
            for (j = 0; j < row_len + zeros; j++) begin
                send_entry((j < row_len) ? cur : PART_BITS'(0), j == row_len + zeros - 1);
                if ($urandom_range(3) == 0) begin
                    cur = PART_BITS'(1);
                end
                else begin
                    cur = PART_BITS'($urandom_range(1, cur));
                end
            end
        end
        else begin
            for (j = 0; j < row_len; j++) begin
                case ($urandom_range(3))
                    0:       noise = PART_BITS'(0);
                    1:       noise = PART_BITS'($urandom_range(1, 3));
                    default: noise = PART_BITS'($urandom);
                endcase
                send_entry(noise, j == row_len - 1);
            end
        end
    endtask

    initial
    begin
        int phase;
        int phase_start;
        int j;
        logic [TOTAL_BITS-1:0] total;

        part_bus.valid      <= 1'b0;
        part_bus.part_value <= '0;
        part_bus.row_end    <= 1'b0;
        cfg_bus.valid       <= 1'b0;
        cfg_bus.index       <= '0;
        cfg_bus.data        <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: part count with n of zero, starting with an empty row.
        send_entry(PART_BITS'(0), 1'b1);
        send_entry(PART_BITS'(4095), 1'b0);
        send_entry(PART_BITS'(1), 1'b1);
        drain_results();

        // Entries after the first zero are not parts.
        write_config(MODE_LARGEST_PART, TOTAL_BITS'(4095));
        send_entry(PART_BITS'(7), 1'b0);
        send_entry(PART_BITS'(3), 1'b0);
        send_entry(PART_BITS'(0), 1'b0);
        send_entry(PART_BITS'(5), 1'b1);
        drain_results();

        // A rank below zero saturates at zero.
        write_config(MODE_RANK, TOTAL_BITS'(0));
        for (j = 0; j < 4; j++) begin
            send_entry(PART_BITS'(1), j == 3);
        end
        drain_results();

        write_config(MODE_RANK, TOTAL_BITS'(4095));
        send_entry(PART_BITS'(4095), 1'b0);
        send_entry(PART_BITS'(4095), 1'b1);
        drain_results();

        write_config(MODE_CRANK, TOTAL_BITS'(4095));
        send_entry(PART_BITS'(4095), 1'b0);
        send_entry(PART_BITS'(1), 1'b1);
        send_entry(PART_BITS'(5), 1'b0);
        send_entry(PART_BITS'(3), 1'b1);
        send_entry(PART_BITS'(0), 1'b1);
        drain_results();

        // A crank below zero, and a row whose only one lies after a zero.
        write_config(MODE_CRANK, TOTAL_BITS'(0));
        send_entry(PART_BITS'(3), 1'b0);
        for (j = 0; j < 4; j++) begin
            send_entry(PART_BITS'(1), 1'b0);
        end
        send_entry(PART_BITS'(1), 1'b1);
        send_entry(PART_BITS'(2), 1'b0);
        send_entry(PART_BITS'(0), 1'b0);
        send_entry(PART_BITS'(1), 1'b1);
        drain_results();

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase % 3)
                0:       total = TOTAL_BITS'(0);
                1:       total = TOTAL_BITS'(4095);
                default: total = TOTAL_BITS'($urandom);
            endcase
            write_config(MODE_BITS'(phase % 4), total);
            case ((phase / 2) % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 55;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 55;
                end
                default:
                begin
                    send_idle_pct = 15;
                    stall_pct     = 15;
                end
            endcase
            if (phase == 5 || phase == 9) begin
                hold_requests++;
            end
            phase_start = entries_sent;
            // Row longer than the store, all ones: the tail is dropped.
            if (phase == 3) begin
                for (j = 0; j < MAX_ENTRIES + 2; j++) begin
                    send_entry(PART_BITS'(1), j == MAX_ENTRIES + 1);
                end
            end
            while (entries_sent - phase_start < PHASE_ITEMS) begin
                send_random_row();
            end
            drain_results();
        end

        if (fail_count == 0 && pending_results == 0) begin
            $display("tb: success");
        end
        else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
